>>> sv/atc_pkg.sv
package atc_pkg;

  typedef struct packed {
    logic [7:0] text_char;
    logic       end_of_text;
  } atc_in_t;

  typedef struct packed {
    logic signed [31:0] code_value;
    logic [1:0]         status;
  } atc_out_t;

  // Literal classification flags that travel with each finished token.
  typedef struct packed {
    logic overflow;
    logic numeric;
    logic negative;
    logic digit_seen;
  } atc_tok_flags_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  localparam int NUM_MNEM = 27;

  // Mnemonics packed big-endian, right justified, in opcode order.
  localparam logic [63:0] MNEM_TEXT [NUM_MNEM] = '{
    64'("ADD"),   64'("SUB"),   64'("MUL"),    64'("DEC"),   64'("INC"),
    64'("ILT"),   64'("IEQ"),   64'("JMP"),    64'("JMPT"),  64'("JMPF"),
    64'("PUSH"),  64'("AND"),   64'("OR"),     64'("XOR"),   64'("NOT"),
    64'("LOAD"),  64'("GLOAD"), 64'("STORE"),  64'("GSTORE"), 64'("PRINT"),
    64'("POP"),   64'("CALL"),  64'("RET"),    64'("NOP"),   64'("DROP"),
    64'("SWAP"),  64'("EXIT")
  };

  localparam int MNEM_LEN [NUM_MNEM] = '{
    3, 3, 3, 3, 3, 3, 3, 3, 4, 4, 4, 3, 2, 3, 3, 4, 5, 5, 6, 5,
    3, 4, 3, 3, 4, 4, 4
  };

endpackage

>>> sv/atc_front.sv
module atc_front #(
  parameter int MNEMONIC_CHARS = 6,
  parameter int VALUE_BITS     = 32,
  parameter int CW             = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  atc_pkg::atc_in_t            in_data,
  input  logic                        q_full,
  output logic                        q_push,
  output logic [8*MNEMONIC_CHARS-1:0] tok_head,
  output logic [CW-1:0]               tok_count,
  output logic [VALUE_BITS-1:0]       tok_accum,
  output atc_pkg::atc_tok_flags_t     tok_flags
);
  import atc_pkg::*;

  localparam int HW = 8 * MNEMONIC_CHARS;
  localparam int PW = VALUE_BITS + 4;
  localparam logic [PW-1:0] LIMIT = PW'(1) << (VALUE_BITS - 1);

  logic [HW-1:0]         head_r, head_nxt, head_upd;
  logic [CW-1:0]         count_r, count_nxt, count_upd;
  logic [VALUE_BITS-1:0] accum_r, accum_nxt, accum_upd;
  atc_tok_flags_t        flags_r, flags_nxt, flags_upd;

  logic       accept, is_sep, is_digit, first;
  logic [3:0] digit;
  logic [PW-1:0] prod;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign is_sep   = (in_data.text_char == CH_SPACE) || (in_data.text_char == CH_NEWLINE);
  assign is_digit = (in_data.text_char >= CH_ZERO) && (in_data.text_char <= CH_NINE);
  assign digit    = in_data.text_char[3:0];
  assign first    = (count_r == '0);
  assign prod     = PW'({accum_r, 3'b000}) + PW'({accum_r, 1'b0}) + PW'(digit);

  always_comb begin
    head_upd  = head_r;
    count_upd = count_r;
    accum_upd = accum_r;
    flags_upd = flags_r;
    if (count_r < CW'(MNEMONIC_CHARS)) begin
      head_upd = {head_r[HW-9:0], in_data.text_char};
    end
    if (count_r <= CW'(MNEMONIC_CHARS)) begin
      count_upd = count_r + CW'(1);
    end
    if (flags_r.numeric) begin
      if (is_digit) begin
        flags_upd.digit_seen = 1'b1;
        if (!flags_r.overflow) begin
          // accum*10 + d beyond the magnitude limit marks the literal as out of range.
          if (prod > LIMIT) begin
            flags_upd.overflow = 1'b1;
          end else begin
            accum_upd = prod[VALUE_BITS-1:0];
          end
        end
      end else if (first && (in_data.text_char == CH_PLUS ||
                             in_data.text_char == CH_MINUS)) begin
        flags_upd.negative = (in_data.text_char == CH_MINUS);
      end else begin
        flags_upd.numeric = 1'b0;
      end
    end
  end

  // A separator closes the token held so far; end of text on any other
  // byte closes the token including that byte.
  always_comb begin
    q_push    = accept && ((is_sep && !first) || (!is_sep && in_data.end_of_text));
    tok_head  = is_sep ? head_r  : head_upd;
    tok_count = is_sep ? count_r : count_upd;
    tok_accum = is_sep ? accum_r : accum_upd;
    tok_flags = is_sep ? flags_r : flags_upd;
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    accum_nxt = accum_r;
    flags_nxt = flags_r;
    if (accept) begin
      if (is_sep || in_data.end_of_text) begin
        head_nxt  = '0;
        count_nxt = '0;
        accum_nxt = '0;
        flags_nxt = '{overflow: 1'b0, numeric: 1'b1, negative: 1'b0, digit_seen: 1'b0};
      end else begin
        head_nxt  = head_upd;
        count_nxt = count_upd;
        accum_nxt = accum_upd;
        flags_nxt = flags_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      accum_r <= '0;
      flags_r <= '{overflow: 1'b0, numeric: 1'b1, negative: 1'b0, digit_seen: 1'b0};
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      accum_r <= accum_nxt;
      flags_r <= flags_nxt;
    end
  end

endmodule

>>> sv/atc_fifo.sv
module atc_fifo #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTRW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;

  assign full     = (count_r == CNTW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_r + PTRW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_r + PTRW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNTW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> sv/atc_back.sv
module atc_back #(
  parameter int MNEMONIC_CHARS = 6,
  parameter int VALUE_BITS     = 32,
  parameter int CW             = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        tok_valid,
  output logic                        tok_pop,
  input  logic [8*MNEMONIC_CHARS-1:0] tok_head,
  input  logic [CW-1:0]               tok_count,
  input  logic [VALUE_BITS-1:0]       tok_accum,
  input  atc_pkg::atc_tok_flags_t     tok_flags,
  output logic                        out_valid,
  input  logic                        out_ready,
  output atc_pkg::atc_out_t           out_data
);
  import atc_pkg::*;

  localparam int NW = (VALUE_BITS > 32) ? VALUE_BITS : 32;
  localparam logic [VALUE_BITS-1:0] LIMIT = VALUE_BITS'(1) << (VALUE_BITS - 1);

  logic     out_valid_r, out_valid_nxt;
  atc_out_t out_data_r, out_data_nxt;
  atc_out_t result;

  logic          over, found;
  logic [NW-1:0] mag;
  logic [31:0]   op_code;

  assign tok_pop = tok_valid && (!out_valid_r || out_ready);

  always_comb begin
    found   = 1'b0;
    op_code = '0;
    for (int k = 0; k < NUM_MNEM; k++) begin
      if (64'(tok_head) == MNEM_TEXT[k] && tok_count == CW'(MNEM_LEN[k])) begin
        found   = 1'b1;
        op_code = op_code | 32'(k);
      end
    end
  end

  always_comb begin
    over = tok_flags.overflow || (!tok_flags.negative && tok_accum == LIMIT);
    mag  = tok_flags.negative ? NW'(0) - NW'(tok_accum) : NW'(tok_accum);
    if (tok_flags.numeric && tok_flags.digit_seen) begin
      if (over) begin
        result.code_value = '0;
        result.status     = ST_RANGE;
      end else begin
        result.code_value = mag[31:0];
        result.status     = ST_OK;
      end
    end else if (tok_count > CW'(MNEMONIC_CHARS) || !found) begin
      result.code_value = '0;
      result.status     = ST_UNKNOWN;
    end else begin
      result.code_value = op_code;
      result.status     = ST_OK;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (tok_pop) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = result;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sv/assembly_token_to_code_core.sv
// Channel | Direction | Payload                          | Handshake
// in_     | input     | atc_in_t  (text_char, end_of_text) | in_valid / in_ready
// out_    | output    | atc_out_t (code_value, status)     | out_valid / out_ready
//
// One character is taken per cycle while in_ready is high; a token's code reaches
// out_ by way of the queue write and then the coder register.
// Reset (rst_n low, synchronous) clears the token state, the queue and out_valid.
// A two-entry queue separates the character front from the mnemonic coder, so
// in_ready drops only when that queue is full, which only an output stall brings about.
module assembly_token_to_code_core #(
  parameter int MNEMONIC_CHARS = 6,
  parameter int VALUE_BITS     = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  atc_pkg::atc_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output atc_pkg::atc_out_t  out_data
);
  import atc_pkg::*;

  localparam int HW = 8 * MNEMONIC_CHARS;
  localparam int CW = $clog2(MNEMONIC_CHARS + 2);
  localparam int FW = $bits(atc_tok_flags_t);
  localparam int QW = HW + CW + VALUE_BITS + FW;

  logic                  q_full, q_push, q_pop, q_valid;
  logic [HW-1:0]         f_head, b_head;
  logic [CW-1:0]         f_count, b_count;
  logic [VALUE_BITS-1:0] f_accum, b_accum;
  atc_tok_flags_t        f_flags, b_flags;
  logic [QW-1:0]         q_rd_data;

  atc_front #(
    .MNEMONIC_CHARS(MNEMONIC_CHARS),
    .VALUE_BITS    (VALUE_BITS),
    .CW            (CW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .tok_head (f_head),
    .tok_count(f_count),
    .tok_accum(f_accum),
    .tok_flags(f_flags)
  );

  atc_fifo #(
    .WIDTH(QW),
    .DEPTH(2)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data({f_head, f_count, f_accum, f_flags}),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_rd_data)
  );

  assign {b_head, b_count, b_accum, b_flags} = q_rd_data;

  atc_back #(
    .MNEMONIC_CHARS(MNEMONIC_CHARS),
    .VALUE_BITS    (VALUE_BITS),
    .CW            (CW)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .tok_valid(q_valid),
    .tok_pop  (q_pop),
    .tok_head (b_head),
    .tok_count(b_count),
    .tok_accum(b_accum),
    .tok_flags(b_flags),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

>>> tb/atc_code_checker.sv
module atc_code_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  atc_pkg::atc_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  atc_pkg::atc_out_t out_data,
  output int unsigned       pending,
  output int unsigned       errors
);
  timeunit 1ns;
  timeprecision 1ps;
  import atc_pkg::*;

  localparam int          NAME_CHARS   = 6;
  localparam int          OPCODE_COUNT = 27;
  localparam logic [63:0] LIT_LIMIT    = 64'h0000_0000_8000_0000;

  string op_names [OPCODE_COUNT] = '{
    "ADD", "SUB", "MUL", "DEC", "INC", "ILT", "IEQ", "JMP", "JMPT",
    "JMPF", "PUSH", "AND", "OR", "XOR", "NOT", "LOAD", "GLOAD", "STORE",
    "GSTORE", "PRINT", "POP", "CALL", "RET", "NOP", "DROP", "SWAP", "EXIT"
  };
  logic [8*NAME_CHARS-1:0] name_bits [OPCODE_COUNT];
  int                      name_len  [OPCODE_COUNT];

  // Token state of the predictor.
  logic [8*NAME_CHARS-1:0] tok_head;
  logic [2:0]              tok_len;
  logic [63:0]             mag;
  logic                    mag_over;
  logic                    maybe_num;
  logic                    is_neg;
  logic                    has_digit;

  atc_out_t    codes_due [$];
  int unsigned err_count = 0;

  initial begin
    for (int k = 0; k < OPCODE_COUNT; k++) begin
      name_bits[k] = '0;
      name_len[k]  = op_names[k].len();
      for (int j = 0; j < name_len[k]; j++) begin
        name_bits[k] = {name_bits[k][8*NAME_CHARS-9:0], 8'(op_names[k][j])};
      end
    end
  end

  function automatic void clear_token();
    tok_head  = '0;
    tok_len   = '0;
    mag       = '0;
    mag_over  = 1'b0;
    maybe_num = 1'b1;
    is_neg    = 1'b0;
    has_digit = 1'b0;
  endfunction

  function automatic void take_char(logic [7:0] c);
    logic [63:0] d;
    logic        first;
    first = (tok_len == 0);
    if (tok_len < NAME_CHARS) tok_head = {tok_head[8*NAME_CHARS-9:0], c};
    if (tok_len <= NAME_CHARS) tok_len = tok_len + 3'd1;
    if (maybe_num) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        d = c - CH_ZERO;
        has_digit = 1'b1;
        // Once the magnitude has passed the range it stops growing.
        if (!mag_over) begin
          if (mag > (LIT_LIMIT - d) / 10) mag_over = 1'b1;
          else mag = mag * 10 + d;
        end
      end else if (first && (c == CH_PLUS || c == CH_MINUS)) begin
        is_neg = (c == CH_MINUS);
      end else begin
        maybe_num = 1'b0;
      end
    end
  endfunction

  function automatic atc_out_t code_of_token();
    atc_out_t    r;
    logic [63:0] v;
    r.code_value = '0;
    r.status     = ST_UNKNOWN;
    if (maybe_num && has_digit) begin
      // The positive side of the range is one short of the negative side.
      if (mag_over || (!is_neg && mag == LIT_LIMIT)) begin
        r.status = ST_RANGE;
      end else begin
        v = is_neg ? (64'd0 - mag) : mag;
        r.code_value = v[31:0];
        r.status     = ST_OK;
      end
    end else if (tok_len <= NAME_CHARS) begin
      for (int k = 0; k < OPCODE_COUNT; k++) begin
        if (name_len[k] == tok_len && name_bits[k] == tok_head) begin
          r.code_value = k;
          r.status     = ST_OK;
        end
      end
    end
    return r;
  endfunction

  function automatic void predict_beat(logic [7:0] c, logic eot);
    logic produced;
    produced = 1'b0;
    if (c == CH_SPACE || c == CH_NEWLINE) begin
      if (tok_len > 0) begin
        codes_due.insert(codes_due.size(), code_of_token());
        clear_token();
        produced = 1'b1;
      end
    end else begin
      take_char(c);
    end
    if (eot) begin
      if (!produced && tok_len > 0) codes_due.insert(codes_due.size(), code_of_token());
      clear_token();
    end
  endfunction

  always @(posedge clk) begin
    atc_out_t due;
    if (!rst_n) begin
      clear_token();
      codes_due.delete();
    end else begin
      if (in_valid && in_ready) predict_beat(in_data.text_char, in_data.end_of_text);
      if (out_valid && out_ready) begin
        if (codes_due.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result beat code_value %0d status %0d", $time,
                   out_data.code_value, out_data.status);
        end else begin
          due = codes_due.pop_front();
          if (out_data.code_value !== due.code_value) begin
            err_count++;
            $display("%0t: code_value mismatch: expected %0d actual %0d", $time,
                     due.code_value, out_data.code_value);
          end
          if (out_data.status !== due.status) begin
            err_count++;
            $display("%0t: status mismatch: expected %0d actual %0d", $time,
                     due.status, out_data.status);
          end
        end
      end
    end
    pending <= codes_due.size();
    errors  <= err_count;
  end

endmodule

>>> tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import atc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  atc_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  atc_out_t    out_data;
  int unsigned pending;
  int unsigned fail_total;

  int send_idle_pct = 20;
  int recv_idle_pct = 60;
  int idle_cycles   = 0;

  logic [7:0] word_q [$];

  assembly_token_to_code_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  atc_code_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .pending   (pending),
    .errors    (fail_total)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // A stretch without a beat on either channel that outlasts the watchdog limit means the block is stuck.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic put_beat(input logic [7:0] c, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{text_char: c, end_of_text: eot};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic put_text(input string s, input logic eot_last);
    for (int i = 0; i < s.len(); i++) begin
      put_beat(8'(s[i]), eot_last && (i == s.len() - 1));
    end
  endtask

  // The pending count is registered in the checker, so look only after the next edge.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic void add_char(input logic [7:0] b);
    word_q.insert(word_q.size(), b);
  endfunction

  task automatic make_word();
    int              kind;
    int              k;
    int              j;
    int              pos;
    string           digits;
    longint unsigned mag;
    word_q.delete();
    kind = $urandom_range(99);
    if (kind < 45) begin
      k = $urandom_range(NUM_MNEM - 1);
      for (j = MNEM_LEN[k] - 1; j >= 0; j--) add_char(MNEM_TEXT[k][8*j +: 8]);
      // A near miss now and then: one letter off, one too many or too few, wrong case.
      if ($urandom_range(4) == 0) begin
        pos = $urandom_range(word_q.size() - 1);
        case ($urandom_range(3))
          0: word_q[pos] = 8'($urandom_range(65, 90));
          1: add_char(8'($urandom_range(65, 90)));
          2: if (word_q.size() > 1) void'(word_q.pop_back());
          default: word_q[pos] = word_q[pos] ^ 8'h20;
        endcase
      end
    end else if (kind < 80) begin
      case ($urandom_range(3))
        0: mag = $urandom_range(999);
        1: mag = $urandom;
        2: mag = 64'h8000_0000 - 2 + $urandom_range(4);
        default: mag = {$urandom, $urandom} >> $urandom_range(40);
      endcase
      pos = $urandom_range(2);
      if (pos == 1) add_char(CH_PLUS);
      else if (pos == 2) add_char(CH_MINUS);
      if ($urandom_range(9) == 0) repeat ($urandom_range(1, 3)) add_char(CH_ZERO);
      digits = $sformatf("%0d", mag);
      for (j = 0; j < digits.len(); j++) add_char(8'(digits[j]));
      if ($urandom_range(19) == 0) begin
        word_q.insert($urandom_range(word_q.size()), 8'($urandom_range(33, 126)));
      end
    end else if (kind < 95) begin
      repeat ($urandom_range(1, 9)) add_char(8'($urandom_range(255)));
    end else begin
      add_char($urandom_range(1) ? CH_PLUS : CH_MINUS);
      if ($urandom_range(1)) add_char(8'($urandom_range(65, 90)));
    end
  endtask

  task automatic run_phase(input int s_idle, input int r_idle, input int budget);
    int sent;
    int eot_pick;
    int nsep;
    int j;
    sent          = 0;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    while (sent < budget) begin
      make_word();
      eot_pick = $urandom_range(19);
      foreach (word_q[i]) put_beat(word_q[i], (eot_pick == 0) && (i == word_q.size() - 1));
      sent += word_q.size();
      // Without a separator, neighbor tokens merge into one.
      if (eot_pick == 0 || $urandom_range(29) == 0) nsep = $urandom_range(1);
      else nsep = $urandom_range(1, 3);
      for (j = 0; j < nsep; j++) begin
        put_beat($urandom_range(1) ? CH_SPACE : CH_NEWLINE, (eot_pick == 1) && (j == nsep - 1));
      end
      sent += nsep;
      if ($urandom_range(99) == 0) hold_until_drained();
    end
    hold_until_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Every mnemonic, the literal range edges, lone signs, overlong names.
    put_text("ADD SUB MUL DEC INC ILT IEQ JMP JMPT JMPF PUSH AND OR XOR NOT\n", 1'b0);
    put_text("LOAD GLOAD STORE GSTORE PRINT POP CALL RET NOP DROP SWAP EXIT\n", 1'b0);
    put_text("  2147483647 -2147483648 +2147483647 2147483648 -2147483649 \n\n", 1'b0);
    put_text("0 -0 +007 99999999999 - + +- 12a A1 GSTOREX PUSHX add ", 1'b0);
    // A zero byte is an ordinary character inside a token.
    put_beat("O", 1'b0);
    put_beat(8'h00, 1'b0);
    put_beat("R", 1'b0);
    put_beat(CH_SPACE, 1'b0);
    put_beat(8'hFF, 1'b0);
    put_beat(CH_NEWLINE, 1'b0);
    // End of text flushes an open token, closes on a separator, or finds nothing.
    put_text("EXIT", 1'b1);
    put_beat(CH_SPACE, 1'b1);
    put_text("NOP\n", 1'b1);
    put_text("12", 1'b1);
    put_text("34 ", 1'b0);
    hold_until_drained();

    run_phase(20, 60, 420);
    run_phase(60, 20, 420);
    run_phase(0, 0, 420);

    put_beat(CH_NEWLINE, 1'b1);
    hold_until_drained();
    repeat (8) @(posedge clk);
    if (fail_total == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
